[rtl/first_match_range_rule_classifier_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef FIRST_MATCH_RANGE_RULE_CLASSIFIER_UNIT_DEFINES_SVH
`define FIRST_MATCH_RANGE_RULE_CLASSIFIER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FMRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmrc check failed");
// Implication with the consequent in the next cycle.
`define FMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fmrc check failed");
`endif

[rtl/fmrc_pkg.sv]
// Package of types and constants for the first-match range rule classifier.
`default_nettype none
package fmrc_pkg;
	localparam int unsigned RULES_DEF     = 64;
	localparam int unsigned ENGINES_DEF   = 5;
	localparam int unsigned EXECUTORS_DEF = 7;
	localparam int unsigned TEMPLATES_DEF = 16;

	localparam logic [3:0] FS_OP      = 4'd0;
	localparam logic [3:0] FS_DTYPE   = 4'd1;
	localparam logic [3:0] FS_EN      = 4'd2;
	localparam logic [3:0] FS_RMIN    = 4'd3;
	localparam logic [3:0] FS_RMAX    = 4'd4;
	localparam logic [3:0] FS_BMIN    = 4'd5;
	localparam logic [3:0] FS_BMAX    = 4'd6;
	localparam logic [3:0] FS_NMIN    = 4'd7;
	localparam logic [3:0] FS_NMAX    = 4'd8;
	localparam logic [3:0] FS_SMIN    = 4'd9;
	localparam logic [3:0] FS_ENGINE  = 4'd10;
	localparam logic [3:0] FS_EXEC    = 4'd11;
	localparam logic [3:0] FS_TMPL    = 4'd12;
	localparam logic [3:0] FS_COST    = 4'd13;
	localparam logic [3:0] FS_HASCOST = 4'd14;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] REG_RANKS   = 2'd0;
	localparam logic [1:0] REG_NPUS    = 2'd1;
	localparam logic [1:0] REG_SERVERS = 2'd2;
	localparam logic [1:0] REG_RULES   = 2'd3;

	// Lookup key broadcast to every cell.
	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  dtype;
		logic [47:0] bytes;
		logic [31:0] ranks;
		logic [31:0] npus;
		logic [31:0] servers;
	} key_t;

	// Rule field write broadcast to every cell.
	typedef struct packed {
		logic        en;
		logic [3:0]  sel;
		logic [47:0] value;
	} wr_t;

	// Result of one cell.
	typedef struct packed {
		logic        hit;
		logic [23:0] target;
		logic        has_cost;
		logic [31:0] cost;
	} hit_t;
endpackage
`default_nettype wire

[rtl/fmrc_cell.sv]
// One rule cell: stores a rule and compares it against the broadcast key.
`default_nettype none
module fmrc_cell (
	input  wire logic          clk,
	input  wire fmrc_pkg::wr_t wr,
	input  wire fmrc_pkg::key_t key,
	input  wire logic          active,
	output fmrc_pkg::hit_t     res
);
	logic [3:0]  op_q;
	logic [4:0]  dtype_q;
	logic [7:0]  en_q;
	logic [31:0] rmin_q, rmax_q, nmin_q, nmax_q, smin_q;
	logic [47:0] bmin_q, bmax_q;
	logic [7:0]  eng_q, exe_q, tpl_q;
	logic [31:0] cost_q;
	logic        hc_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			unique case (wr.sel)
				fmrc_pkg::FS_OP:      op_q    <= wr.value[3:0];
				fmrc_pkg::FS_DTYPE:   dtype_q <= wr.value[4:0];
				fmrc_pkg::FS_EN:      en_q    <= wr.value[7:0];
				fmrc_pkg::FS_RMIN:    rmin_q  <= wr.value[31:0];
				fmrc_pkg::FS_RMAX:    rmax_q  <= wr.value[31:0];
				fmrc_pkg::FS_BMIN:    bmin_q  <= wr.value;
				fmrc_pkg::FS_BMAX:    bmax_q  <= wr.value;
				fmrc_pkg::FS_NMIN:    nmin_q  <= wr.value[31:0];
				fmrc_pkg::FS_NMAX:    nmax_q  <= wr.value[31:0];
				fmrc_pkg::FS_SMIN:    smin_q  <= wr.value[31:0];
				fmrc_pkg::FS_ENGINE:  eng_q   <= wr.value[7:0];
				fmrc_pkg::FS_EXEC:    exe_q   <= wr.value[7:0];
				fmrc_pkg::FS_TMPL:    tpl_q   <= wr.value[7:0];
				fmrc_pkg::FS_COST:    cost_q  <= wr.value[31:0];
				fmrc_pkg::FS_HASCOST: hc_q    <= wr.value[0];
				default: ;
			endcase
		end
	end

	logic ok;
	always_comb begin
		ok = active && (op_q == key.op);
		if (en_q[0] && key.ranks < rmin_q) ok = 1'b0;
		if (en_q[1] && key.ranks > rmax_q) ok = 1'b0;
		if (en_q[2] && key.bytes < bmin_q) ok = 1'b0;
		if (en_q[3] && key.bytes > bmax_q) ok = 1'b0;
		if (en_q[4] && dtype_q != key.dtype) ok = 1'b0;
		if (en_q[5] && key.npus < nmin_q) ok = 1'b0;
		if (en_q[6] && key.npus > nmax_q) ok = 1'b0;
		if (en_q[7] && key.servers < smin_q) ok = 1'b0;
	end

	assign res.hit      = ok;
	assign res.target   = {tpl_q, exe_q, eng_q};
	assign res.has_cost = hc_q;
	assign res.cost     = cost_q;
endmodule
`default_nettype wire

[rtl/fmrc_scan.sv]
// Priority stage of the chain: hits registered at start, first index wins.
`default_nettype none
module fmrc_scan #(
	parameter int unsigned RULES = fmrc_pkg::RULES_DEF,
	parameter int unsigned IW    = (RULES > 1) ? $clog2(RULES) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire fmrc_pkg::hit_t         hits [RULES],
	output logic                        done,
	output logic                        found,
	output logic [IW-1:0]               idx,
	output fmrc_pkg::hit_t              sel
);
	// Hit vector latched on start; then the index walks one rule per cycle.
	logic [RULES-1:0] hv_q;
	logic [IW-1:0]    pos_q;
	logic             busy_q;
	logic [IW:0]      pos_n;

	assign pos_n = {1'b0, pos_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			hv_q   <= '0;
			done   <= 1'b0;
			found  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				for (int i = 0; i < RULES; i++) hv_q[i] <= hits[i].hit;
				busy_q <= 1'b1;
				pos_q  <= '0;
				found  <= 1'b0;
			end else if (busy_q) begin
				if (hv_q[pos_q]) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					found  <= 1'b1;
				end else if (pos_n == IW'(RULES) + (IW+1)'(0) || pos_n[IW-1:0] == '0 &&
						RULES == (1 << IW)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					pos_q <= pos_n[IW-1:0];
				end
			end
		end
	end

	assign idx = pos_q;
	assign sel = hits[pos_q];
endmodule
`default_nettype wire

[rtl/first_match_range_rule_classifier_unit.sv]
// Top level of the first-match range rule classifier.
//  channel  dir  handshake       payload
//  in       in   valid/ready     command rule_index field_select field_value op_type ...
//  out      out  out_valid/ready matched applied matched_rule table_index cost_bits
//  apb      in   psel/penable    paddr pwdata prdata
// A write command passes through the load state to the output state.
// A lookup latches all cell hits in the load state; the priority scanner then walks
// one rule per cycle until the first hit or the last rule, and the result is output.
// One item is in work at a time; ready is low until its result is taken.
// Reset clears the configuration registers; rule storage is undefined until written.
`default_nettype none
module first_match_range_rule_classifier_unit #(
	parameter int unsigned RULES     = fmrc_pkg::RULES_DEF,
	parameter int unsigned ENGINES   = fmrc_pkg::ENGINES_DEF,
	parameter int unsigned EXECUTORS = fmrc_pkg::EXECUTORS_DEF,
	parameter int unsigned TEMPLATES = fmrc_pkg::TEMPLATES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [5:0]  rule_index,
	input  wire logic [3:0]  field_select,
	input  wire logic [47:0] field_value,
	input  wire logic [3:0]  op_type,
	input  wire logic [4:0]  data_type,
	input  wire logic [47:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             matched,
	output logic             applied,
	output logic [5:0]       matched_rule,
	output logic [9:0]       table_index,
	output logic [31:0]      cost_bits,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int unsigned IW = (RULES > 1) ? $clog2(RULES) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] ranks_q, npus_q, servers_q;
	logic [6:0]  rcount_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranks_q <= '0; npus_q <= '0; servers_q <= '0; rcount_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_RANKS_C:   ranks_q   <= pwdata;
				REG_NPUS_C:    npus_q    <= pwdata;
				REG_SERVERS_C: servers_q <= pwdata;
				default:       rcount_q  <= pwdata[6:0];
			endcase
		end
	end
	localparam logic [1:0] REG_RANKS_C   = fmrc_pkg::REG_RANKS;
	localparam logic [1:0] REG_NPUS_C    = fmrc_pkg::REG_NPUS;
	localparam logic [1:0] REG_SERVERS_C = fmrc_pkg::REG_SERVERS;

	always_comb begin
		unique case (paddr[3:2])
			fmrc_pkg::REG_RANKS:   prdata = ranks_q;
			fmrc_pkg::REG_NPUS:    prdata = npus_q;
			fmrc_pkg::REG_SERVERS: prdata = servers_q;
			default:               prdata = {25'd0, rcount_q};
		endcase
	end

	// Input item register.
	fmrc_pkg::key_t key_q;
	logic           cmd_q;
	logic [5:0]     ridx_q;
	logic [3:0]     fsel_q;
	logic [47:0]    fval_q;
	logic           acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q         <= command;
			ridx_q        <= rule_index;
			fsel_q        <= field_select;
			fval_q        <= field_value;
			key_q.op      <= op_type;
			key_q.dtype   <= data_type;
			key_q.bytes   <= byte_count;
			key_q.ranks   <= ranks_q;
			key_q.npus    <= npus_q;
			key_q.servers <= servers_q;
		end
	end

	fmrc_pkg::hit_t hits [RULES];
	fmrc_pkg::hit_t sel;
	logic           scan_done, scan_found;
	logic [IW-1:0]  scan_idx;

	for (genvar g = 0; g < RULES; g++) begin : g_cell
		fmrc_pkg::wr_t wr_g;
		logic          act_g;
		assign wr_g.en    = (state_q == ST_LOAD) && (cmd_q == fmrc_pkg::CMD_WRITE) &&
			({1'b0, ridx_q} == 7'(g));
		assign wr_g.sel   = fsel_q;
		assign wr_g.value = fval_q;
		assign act_g      = 32'(g) < 32'(rcount_q);
		fmrc_cell u_cell (.clk(clk), .wr(wr_g), .key(key_q), .active(act_g), .res(hits[g]));
	end

	fmrc_scan #(.RULES(RULES), .IW(IW)) u_scan (
		.clk(clk), .arst_n(arst_n),
		.start((state_q == ST_LOAD) && (cmd_q == fmrc_pkg::CMD_LOOKUP)),
		.hits(hits), .done(scan_done), .found(scan_found), .idx(scan_idx), .sel(sel)
	);

	// Target decode of the selected rule.
	logic signed [7:0] e, x, t;
	logic              in_rng;
	logic [31:0]       flat;
	assign e = sel.target[7:0];
	assign x = sel.target[15:8];
	assign t = sel.target[23:16];
	assign in_rng = !e[7] && !x[7] && !t[7] && (32'(e) < 32'(ENGINES)) &&
		(32'(x) < 32'(EXECUTORS)) && (32'(t) < 32'(TEMPLATES));
	assign flat = 32'(e) * 32'(EXECUTORS * TEMPLATES) + 32'(x) * 32'(TEMPLATES) + 32'(t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (acc) state_q <= ST_LOAD;
				ST_LOAD: begin
					if (cmd_q == fmrc_pkg::CMD_WRITE) begin
						matched <= 1'b0; applied <= 1'b0; matched_rule <= '0;
						table_index <= '0; cost_bits <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: if (scan_done) begin
					matched      <= scan_found;
					applied      <= scan_found && in_rng;
					matched_rule <= scan_found ? 6'(scan_idx) : 6'd0;
					table_index  <= (scan_found && in_rng) ? flat[9:0] : 10'd0;
					cost_bits    <= (scan_found && in_rng && sel.has_cost) ? sel.cost : 32'd0;
					state_q      <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == ST_OUT);
endmodule
`default_nettype wire

[rtl/fmrc_checker.sv]
// Port-level checker for the classifier, bound to the top level.
`default_nettype none
`include "first_match_range_rule_classifier_unit_defines.svh"
module fmrc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       matched,
	input wire logic       applied,
	input wire logic [9:0] table_index,
	input wire logic [31:0] cost_bits,
	input wire logic       pready
);
	`FMRC_ASSERT_IMP(a_applied_needs_match, clk, arst_n, out_valid && applied, matched)
	`FMRC_ASSERT_IMP(a_idx_zero, clk, arst_n, out_valid && !applied, table_index == 10'd0 && cost_bits == 32'd0)
	`FMRC_ASSERT_IMP(a_one_item, clk, arst_n, out_valid, !in_ready)
	`FMRC_ASSERT_NEXT(a_in_blocks, clk, arst_n, in_valid && in_ready, !in_ready)
	`FMRC_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind first_match_range_rule_classifier_unit fmrc_checker u_fmrc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .matched(matched), .applied(applied),
	.table_index(table_index), .cost_bits(cost_bits), .pready(pready)
);
`default_nettype wire

[tb/first_match_range_rule_classifier_unit_tb.sv]
// Self-checking testbench for the first-match range rule classifier: directed table, then random phases.
`default_nettype none
module first_match_range_rule_classifier_unit_tb;
	import fmrc_pkg::*;

	localparam int unsigned NRULES     = RULES_DEF;
	localparam logic [3:0]  FS_UNKNOWN = 4'd15;
	localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;
	localparam int          PHASES     = 15;
	localparam int          PER_PHASE  = 60;
	localparam int          LIMIT      = 1000000;

	typedef struct packed {
		logic        matched;
		logic        applied;
		logic [5:0]  rule;
		logic [9:0]  tidx;
		logic [31:0] cost;
	} result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic        cmd;
		logic [5:0]  idx;
		logic [3:0]  sel;
		logic [47:0] val;
		logic [3:0]  op;
		logic [4:0]  dt;
		logic [47:0] bytes;
		bit          typed;
		result_t     res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [5:0]  rule_index;
	logic [3:0]  field_select;
	logic [47:0] field_value;
	logic [3:0]  op_type;
	logic [4:0]  data_type;
	logic [47:0] byte_count;
	logic        out_valid;
	logic        out_ready;
	logic        matched;
	logic        applied;
	logic [5:0]  matched_rule;
	logic [9:0]  table_index;
	logic [31:0] cost_bits;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	first_match_range_rule_classifier_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .rule_index(rule_index), .field_select(field_select),
		.field_value(field_value), .op_type(op_type), .data_type(data_type),
		.byte_count(byte_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.matched(matched), .applied(applied), .matched_rule(matched_rule),
		.table_index(table_index), .cost_bits(cost_bits),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the rule table and group registers.
	logic [3:0]        r_op [NRULES];
	logic [4:0]        r_dtype [NRULES];
	logic [7:0]        r_en [NRULES];
	logic [31:0]       r_rmin [NRULES];
	logic [31:0]       r_rmax [NRULES];
	logic [47:0]       r_bmin [NRULES];
	logic [47:0]       r_bmax [NRULES];
	logic [31:0]       r_nmin [NRULES];
	logic [31:0]       r_nmax [NRULES];
	logic [31:0]       r_smin [NRULES];
	logic signed [7:0] r_eng [NRULES];
	logic signed [7:0] r_exe [NRULES];
	logic signed [7:0] r_tpl [NRULES];
	logic [31:0]       r_cost [NRULES];
	logic              r_hascost [NRULES];
	logic [14:0]       written [NRULES];
	logic [31:0]       cfg_ranks, cfg_npus, cfg_servers;
	logic [6:0]        cfg_rules;

	result_t pending_q[$];
	int      errors = 0;
	int      cycles = 0;
	bit      quiet = 0;
	bit      hold_req = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	function automatic result_t classify(logic [3:0] op, logic [4:0] dt, logic [47:0] b);
		result_t r;
		int      n, e, x, t, idx;
		bit      hit;
		r = '0;
		n = (cfg_rules < NRULES) ? cfg_rules : NRULES;
		for (int i = 0; i < n; i++) begin
			hit = (r_op[i] == op)
				&& !(r_en[i][0] && cfg_ranks < r_rmin[i])
				&& !(r_en[i][1] && cfg_ranks > r_rmax[i])
				&& !(r_en[i][2] && b < r_bmin[i])
				&& !(r_en[i][3] && b > r_bmax[i])
				&& !(r_en[i][4] && r_dtype[i] != dt)
				&& !(r_en[i][5] && cfg_npus < r_nmin[i])
				&& !(r_en[i][6] && cfg_npus > r_nmax[i])
				&& !(r_en[i][7] && cfg_servers < r_smin[i]);
			if (hit) begin
				e = r_eng[i];
				x = r_exe[i];
				t = r_tpl[i];
				r.matched = 1'b1;
				r.rule = i[5:0];
				if (e >= 0 && e < int'(ENGINES_DEF) && x >= 0 && x < int'(EXECUTORS_DEF)
						&& t >= 0 && t < int'(TEMPLATES_DEF)) begin
					idx = e * int'(EXECUTORS_DEF * TEMPLATES_DEF) + x * int'(TEMPLATES_DEF) + t;
					r.applied = 1'b1;
					r.tidx = idx[9:0];
					r.cost = r_hascost[i] ? r_cost[i] : 32'd0;
				end
				break;
			end
		end
		return r;
	endfunction

	task automatic store_field(input logic [5:0] i, input logic [3:0] sel, input logic [47:0] v);
		case (sel)
			FS_OP:      r_op[i] = v[3:0];
			FS_DTYPE:   r_dtype[i] = v[4:0];
			FS_EN:      r_en[i] = v[7:0];
			FS_RMIN:    r_rmin[i] = v[31:0];
			FS_RMAX:    r_rmax[i] = v[31:0];
			FS_BMIN:    r_bmin[i] = v;
			FS_BMAX:    r_bmax[i] = v;
			FS_NMIN:    r_nmin[i] = v[31:0];
			FS_NMAX:    r_nmax[i] = v[31:0];
			FS_SMIN:    r_smin[i] = v[31:0];
			FS_ENGINE:  r_eng[i] = v[7:0];
			FS_EXEC:    r_exe[i] = v[7:0];
			FS_TMPL:    r_tpl[i] = v[7:0];
			FS_COST:    r_cost[i] = v[31:0];
			FS_HASCOST: r_hascost[i] = v[0];
			default: ;
		endcase
		if (sel != FS_UNKNOWN)
			written[i][sel] = 1'b1;
	endtask

	// Called at a rising edge; returns at the edge of the transfer.
	task automatic send(input logic cmd, input logic [5:0] idx, input logic [3:0] sel,
			input logic [47:0] val, input logic [3:0] op, input logic [4:0] dt,
			input logic [47:0] b, input bit typed, input result_t res);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rule_index <= idx;
		field_select <= sel;
		field_value <= val;
		op_type <= op;
		data_type <= dt;
		byte_count <= b;
		do @(posedge clk); while (!in_ready);
		if (typed)
			pending_q.push_back(res);
		else if (cmd == CMD_LOOKUP)
			pending_q.push_back(classify(op, dt, b));
		else
			pending_q.push_back('0);
		if (cmd == CMD_WRITE)
			store_field(idx, sel, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] reg_id, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_id, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (reg_id)
			REG_RANKS:   cfg_ranks = v;
			REG_NPUS:    cfg_npus = v;
			REG_SERVERS: cfg_servers = v;
			REG_RULES:   cfg_rules = v[6:0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report("unexpected result", 32'd0, 32'd0);
			end else begin
				want = pending_q.pop_front();
				if (matched !== want.matched) report("matched", matched, want.matched);
				if (applied !== want.applied) report("applied", applied, want.applied);
				if (matched_rule !== want.rule) report("matched_rule", matched_rule, want.rule);
				if (table_index !== want.tidx) report("table_index", table_index, want.tidx);
				if (cost_bits !== want.cost) report("cost_bits", cost_bits, want.cost);
			end
		end
	end

	// Result side: short random stalls, calm stretches, and one long hold.
	initial begin
		int stall_left = 0;
		int calm_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !quiet) begin
				stall_left = 300;
				hold_req = 0;
			end else if (calm_left == 0 && $urandom_range(0, 40) == 0) begin
				calm_left = 40;
			end else if (stall_left == 0 && calm_left == 0 && !quiet
					&& $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			out_ready <= (stall_left == 0);
			if (stall_left > 0) stall_left--;
			if (calm_left > 0) calm_left--;
		end
	end

	function automatic row_t wr_row(logic [5:0] i, logic [3:0] sel, logic [47:0] v);
		row_t r;
		r = '{ROW_ITEM, CMD_WRITE, i, sel, v, 4'd0, 5'd0, 48'd0, 1'b1, '0};
		return r;
	endfunction

	function automatic row_t lk_row(logic [3:0] op, logic [4:0] dt, logic [47:0] b,
			bit typed, result_t res);
		row_t r;
		r = '{ROW_ITEM, CMD_LOOKUP, 6'd0, 4'd0, 48'd0, op, dt, b, typed, res};
		return r;
	endfunction

	function automatic row_t cfg_row(logic [1:0] reg_id, logic [31:0] v);
		row_t r;
		r = '{ROW_CFG, CMD_WRITE, 6'd0, {2'b00, reg_id}, {16'd0, v}, 4'd0, 5'd0, 48'd0, 1'b0, '0};
		return r;
	endfunction

	function automatic logic [31:0] pick32(logic [31:0] c);
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return c - 32'd1;
			3: return c + 32'd1;
			4: return $urandom;
			default: return c;
		endcase
	endfunction

	function automatic logic [47:0] pick48();
		logic [47:0] one;
		one = 48'd1 << $urandom_range(0, 47);
		case ($urandom_range(0, 5))
			0: return 48'd0;
			1: return MAX48;
			2: return one;
			3: return one + $urandom_range(0, 3) - 2;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_cfg();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	function automatic logic [47:0] gen_field(logic [3:0] sel);
		logic [15:0] noise;
		logic [7:0]  b;
		noise = $urandom;
		case (sel)
			FS_OP:      return {$urandom, 12'd0, 4'($urandom_range(0, 3))};
			FS_DTYPE:   return {$urandom, 11'd0,
				5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3))};
			FS_EN:      return {$urandom, 8'($urandom)};
			FS_RMIN, FS_RMAX:   return {noise, pick32(cfg_ranks)};
			FS_NMIN, FS_NMAX:   return {noise, pick32(cfg_npus)};
			FS_SMIN:    return {noise, pick32(cfg_servers)};
			FS_BMIN, FS_BMAX:   return pick48();
			FS_ENGINE, FS_EXEC, FS_TMPL: begin
				if ($urandom_range(0, 7) == 0)
					b = $urandom;
				else if (sel == FS_ENGINE)
					b = $urandom_range(0, ENGINES_DEF - 1);
				else if (sel == FS_EXEC)
					b = $urandom_range(0, EXECUTORS_DEF - 1);
				else
					b = $urandom_range(0, TEMPLATES_DEF - 1);
				return {$urandom, noise[7:0], b};
			end
			default:    return {noise, $urandom};
		endcase
	endfunction

	initial begin
		row_t    rows[$];
		result_t hit0;
		result_t miss0;
		int      chosen, live, gap_rule;
		logic [3:0] gap_sel;
		logic [1:0] kind;

		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_WRITE;
		rule_index = '0;
		field_select = FS_OP;
		field_value = '0;
		op_type = '0;
		data_type = '0;
		byte_count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_ranks = '0;
		cfg_npus = '0;
		cfg_servers = '0;
		cfg_rules = '0;
		for (int i = 0; i < NRULES; i++) written[i] = '0;

		hit0 = '{1'b1, 1'b1, 6'd0, 10'd559, 32'hFFFF_FFFF};
		miss0 = '{1'b1, 1'b0, 6'd0, 10'd0, 32'd0};

		// Empty table, one rule with every limit wide open, then target out of range.
		rows.push_back(lk_row(4'hF, 5'h1F, MAX48, 1'b1, '0));
		rows.push_back(wr_row(6'd0, FS_OP, 48'hFFFF_FFFF_FFF3));
		rows.push_back(wr_row(6'd0, FS_DTYPE, 48'hFFFF_FFFF_FFFF));
		rows.push_back(wr_row(6'd0, FS_EN, 48'hFF));
		rows.push_back(wr_row(6'd0, FS_RMIN, 48'd0));
		rows.push_back(wr_row(6'd0, FS_RMAX, 48'h0000_FFFF_FFFF));
		rows.push_back(wr_row(6'd0, FS_BMIN, 48'd0));
		rows.push_back(wr_row(6'd0, FS_BMAX, MAX48));
		rows.push_back(wr_row(6'd0, FS_NMIN, 48'hFFFF_0000_0000));
		rows.push_back(wr_row(6'd0, FS_NMAX, 48'h0000_FFFF_FFFF));
		rows.push_back(wr_row(6'd0, FS_SMIN, 48'd0));
		rows.push_back(wr_row(6'd0, FS_ENGINE, 48'd4));
		rows.push_back(wr_row(6'd0, FS_EXEC, 48'd6));
		rows.push_back(wr_row(6'd0, FS_TMPL, 48'd15));
		rows.push_back(wr_row(6'd0, FS_COST, 48'h0000_FFFF_FFFF));
		rows.push_back(wr_row(6'd0, FS_HASCOST, 48'd1));
		rows.push_back(wr_row(6'd63, FS_UNKNOWN, MAX48));
		rows.push_back(cfg_row(REG_RANKS, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(REG_NPUS, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(REG_SERVERS, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(REG_RULES, 32'd1));
		rows.push_back(lk_row(4'd3, 5'h1F, MAX48, 1'b1, hit0));
		rows.push_back(lk_row(4'd3, 5'h1E, MAX48, 1'b1, '0));
		rows.push_back(lk_row(4'd2, 5'h1F, 48'd0, 1'b1, '0));
		rows.push_back(wr_row(6'd0, FS_ENGINE, 48'd5));
		rows.push_back(lk_row(4'd3, 5'h1F, 48'd0, 1'b1, miss0));
		rows.push_back(wr_row(6'd0, FS_ENGINE, 48'h80));
		rows.push_back(lk_row(4'd3, 5'h1F, 48'd12, 1'b0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			if (rows[k].kind == ROW_CFG) begin
				drain();
				cfg_write(rows[k].sel[1:0], rows[k].val[31:0]);
			end else begin
				send(rows[k].cmd, rows[k].idx, rows[k].sel, rows[k].val, rows[k].op,
					rows[k].dt, rows[k].bytes, rows[k].typed, rows[k].res);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			quiet = (p == PHASES - 1);
			if (p == 1) begin
				cfg_write(REG_RANKS, 32'd0);
				cfg_write(REG_NPUS, 32'd0);
				cfg_write(REG_SERVERS, 32'd0);
				cfg_write(REG_RULES, 32'd0);
			end else begin
				cfg_write(REG_RANKS, pick_cfg());
				cfg_write(REG_NPUS, pick_cfg());
				cfg_write(REG_SERVERS, pick_cfg());
				if (p == PHASES - 2)
					cfg_write(REG_RULES, 32'd64);
				else if (p == PHASES - 1)
					cfg_write(REG_RULES, 32'd127);
				else
					cfg_write(REG_RULES, $urandom_range(1, 8));
			end
			if (p == 3) hold_req = 1;
			chosen = 0;
			while (chosen < PER_PHASE) begin
				live = (cfg_rules < NRULES) ? cfg_rules : NRULES;
				gap_rule = -1;
				for (int i = 0; i < live && gap_rule < 0; i++)
					if (!(&written[i])) gap_rule = i;
				if (gap_rule >= 0) begin
					// A lookup may not reach a rule with an unwritten field, so fill it first.
					gap_sel = 0;
					while (written[gap_rule][gap_sel]) gap_sel++;
					send(CMD_WRITE, gap_rule[5:0], gap_sel, gen_field(gap_sel), $urandom,
						$urandom, pick48(), 1'b0, '0);
				end else begin
					kind = $urandom_range(0, 3);
					gap_sel = $urandom_range(0, 14);
					if ($urandom_range(0, 19) == 0) gap_sel = FS_UNKNOWN;
					gap_rule = ($urandom_range(0, 1) == 0 || live == 0)
						? $urandom_range(0, NRULES - 1) : $urandom_range(0, live - 1);
					if (kind == 0)
						send(CMD_WRITE, gap_rule[5:0], gap_sel, gen_field(gap_sel),
							$urandom, $urandom, pick48(), 1'b0, '0);
					else
						send(CMD_LOOKUP, $urandom, $urandom, {$urandom, $urandom},
							($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
								: $urandom_range(0, 3),
							($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
								: $urandom_range(0, 3),
							pick48(), 1'b0, '0);
					chosen++;
				end
			end
		end

		drain();
		repeat (NRULES + 8) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/fmrc_pkg.sv
rtl/fmrc_cell.sv
rtl/fmrc_scan.sv
rtl/first_match_range_rule_classifier_unit.sv
rtl/fmrc_checker.sv
tb/first_match_range_rule_classifier_unit_tb.sv
